[rtl/llgr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llgr_pkg: shared types and constants of the linked-list group reverse unit
// Widths of the node store, the walk list and the fields, register indexes
// and the sequencer state type.
// ----------------------------------------------------------------------------
package llgr_pkg;

    // Node store and walk list sizes
    localparam int ADDR_BITS   = 10;
    localparam int MAX_NODES   = 64;
    localparam int STORE_DEPTH = 1 << ADDR_BITS;
    localparam int IDX_W       = $clog2(MAX_NODES);
    localparam int CNT_W       = $clog2(MAX_NODES + 1);
    localparam int POS_W       = CNT_W + 1;

    // Field widths
    localparam int NADDR_W = 10;
    localparam int VALUE_W = 32;
    localparam int LINK_W  = 11;
    localparam int GRP_W   = 7;

    localparam logic [LINK_W-1:0] NULL_LINK = {LINK_W{1'b1}};

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_HEAD  = 1'b0;
    localparam logic REG_GROUP = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_EM_ADDR,
        ST_EM_VAL,
        ST_EM_LOAD,
        ST_EM_PUSH,
        ST_EM_LAST
    } llgr_state_t;

endpackage

[rtl/llgr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llgr_if: word channels of the linked-list group reverse unit
// Node record channel into the block and result channel out of it, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface llgr_in_if
    import llgr_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic        [NADDR_W-1:0]  node_addr;
    logic signed [VALUE_W-1:0]  node_value;
    logic signed [LINK_W-1:0]   link_addr;
    logic                       final_record;

    modport source (
        output valid, node_addr, node_value, link_addr, final_record,
        input  ready
    );
    modport sink (
        input  valid, node_addr, node_value, link_addr, final_record,
        output ready
    );
endinterface

interface llgr_out_if
    import llgr_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic        [NADDR_W-1:0]  out_addr;
    logic signed [VALUE_W-1:0]  out_value;
    logic signed [LINK_W-1:0]   out_link;
    logic                       end_of_list;
    logic                       list_empty;
    logic                       truncated;

    modport source (
        output valid, out_addr, out_value, out_link, end_of_list, list_empty,
               truncated,
        input  ready
    );
    modport sink (
        input  valid, out_addr, out_value, out_link, end_of_list, list_empty,
               truncated,
        output ready
    );
endinterface

[rtl/llgr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llgr_ram: generic single-port-write, single-port-read RAM
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module llgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/linked_list_group_reverse_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_group_reverse_unit: relink a stored list in reversed groups
// Loads node records into a node store, walks the list from head_addr on the
// final record and emits the nodes with every full group reversed.
// ----------------------------------------------------------------------------
// A record without the final flag is stored and the block stays ready for
// the next record. The final record is stored, then the list is walked
// through ST_WALK_RD and ST_WALK_CHK for each node (each step waits on the
// registered read of the link store), and the nodes are emitted through
// the walk-list read, then the value-store read, then the value capture,
// then the hand-off to the output word register; a final state sends the
// last word, and an output stall holds the hand-off. The block takes no
// record meanwhile. An empty head gives a single word marked empty.
// The output word register frees the block to take the next record while the
// last word still waits to be taken.
// ----------------------------------------------------------------------------
module linked_list_group_reverse_unit
    import llgr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // word channels
    llgr_in_if.sink            node_in,
    llgr_out_if.source         result_out
);

    // Configuration registers
    logic [LINK_W-1:0] head_reg;
    logic [GRP_W-1:0]  group_reg;
    logic              cfg_wr;

    // Sequencer and datapath registers
    llgr_state_t         state_reg, state_next;
    logic [ADDR_BITS-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic                 trunc_reg, trunc_next;
    logic [POS_W-1:0]     s_reg, s_next;
    logic [GRP_W-1:0]     j_reg, j_next;
    logic                 have_pend_reg, have_pend_next;
    logic [ADDR_BITS-1:0] pend_addr_reg, pend_addr_next;
    logic [VALUE_W-1:0]   pend_value_reg, pend_value_next;
    logic [VALUE_W-1:0]   cur_value_reg, cur_value_next;

    // Output word register
    logic               out_valid_reg;
    logic [NADDR_W-1:0] out_addr_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [LINK_W-1:0]  out_link_reg;
    logic               out_eol_reg;
    logic               out_empty_reg;
    logic               out_trunc_reg;

    // Word pushed into the output register
    logic               push;
    logic [NADDR_W-1:0] push_addr;
    logic [VALUE_W-1:0] push_value;
    logic [LINK_W-1:0]  push_link;
    logic               push_eol;
    logic               push_empty;
    logic               slot_free;

    // Memory ports
    logic                 in_acc;
    logic [LINK_W-1:0]    link_rdata;
    logic [VALUE_W-1:0]   value_rdata;
    logic [ADDR_BITS-1:0] order_rdata;
    logic                 order_we;
    logic [IDX_W-1:0]     order_raddr;

    // Group position arithmetic
    logic [GRP_W-1:0] k_eff;
    logic [POS_W-1:0] grp_end;
    logic             grp_full;
    logic [POS_W-1:0] orig_pos;
    logic [POS_W-1:0] next_pos;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= NULL_LINK;
            group_reg <= GRP_W'(1);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_HEAD:  head_reg  <= pwdata[LINK_W-1:0];
                REG_GROUP: group_reg <= pwdata[GRP_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_HEAD:  prdata = {{(PDATA_W-LINK_W){head_reg[LINK_W-1]}}, head_reg};
            REG_GROUP: prdata = {{(PDATA_W-GRP_W){1'b0}}, group_reg};
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Node stores and walk list
    // ------------------------------------------------------------------
    assign node_in.ready = (state_reg == ST_IDLE);
    assign in_acc        = node_in.valid & node_in.ready;

    llgr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_value_store (
        .clk   (clk),
        .we    (in_acc),
        .waddr (node_in.node_addr[ADDR_BITS-1:0]),
        .wdata (node_in.node_value),
        .raddr (order_rdata),
        .rdata (value_rdata)
    );

    llgr_ram #(
        .WIDTH (LINK_W),
        .DEPTH (STORE_DEPTH)
    ) u_link_store (
        .clk   (clk),
        .we    (in_acc),
        .waddr (node_in.node_addr[ADDR_BITS-1:0]),
        .wdata (node_in.link_addr),
        .raddr (cur_reg),
        .rdata (link_rdata)
    );

    llgr_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (MAX_NODES)
    ) u_order_list (
        .clk   (clk),
        .we    (order_we),
        .waddr (n_reg[IDX_W-1:0]),
        .wdata (cur_reg),
        .raddr (order_raddr),
        .rdata (order_rdata)
    );

    // ------------------------------------------------------------------
    // Map output position to walk position: reverse inside full groups
    // ------------------------------------------------------------------
    assign k_eff    = (group_reg == '0) ? GRP_W'(1) : group_reg;
    assign grp_end  = s_reg + POS_W'(k_eff);
    assign grp_full = (grp_end <= POS_W'(len_reg));
    assign orig_pos = grp_full ? (grp_end - POS_W'(1) - POS_W'(j_reg))
                               : (s_reg + POS_W'(j_reg));
    assign order_raddr = orig_pos[IDX_W-1:0];
    assign next_pos    = s_reg + POS_W'(j_reg) + POS_W'(1);

    assign slot_free = !out_valid_reg || result_out.ready;

    // ------------------------------------------------------------------
    // Sequencer state register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            have_pend_reg <= 1'b0;
            n_reg         <= '0;
            len_reg       <= '0;
            trunc_reg     <= 1'b0;
            s_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            have_pend_reg <= have_pend_next;
            n_reg         <= n_next;
            len_reg       <= len_next;
            trunc_reg     <= trunc_next;
            s_reg         <= s_next;
            j_reg         <= j_next;
        end
    end

    // Payload registers of the sequencer
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        pend_addr_reg  <= pend_addr_next;
        pend_value_reg <= pend_value_next;
        cur_value_reg  <= cur_value_next;
    end

    // ------------------------------------------------------------------
    // Sequencer next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        n_next          = n_reg;
        len_next        = len_reg;
        trunc_next      = trunc_reg;
        s_next          = s_reg;
        j_next          = j_reg;
        have_pend_next  = have_pend_reg;
        pend_addr_next  = pend_addr_reg;
        pend_value_next = pend_value_reg;
        cur_value_next  = cur_value_reg;
        order_we        = 1'b0;
        push            = 1'b0;
        push_addr       = NADDR_W'(pend_addr_reg);
        push_value      = pend_value_reg;
        push_link       = {{(LINK_W-ADDR_BITS){1'b0}}, cur_reg};
        push_eol        = 1'b0;
        push_empty      = 1'b0;

        case (state_reg)
            // take records; on the final one start the walk, or report an empty list
            ST_IDLE:
            begin
                if (in_acc && node_in.final_record)
                begin
                    if (head_reg[LINK_W-1])
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        cur_next   = head_reg[ADDR_BITS-1:0];
                        n_next     = '0;
                        state_next = ST_WALK_RD;
                    end
                end
            end

            // single word for an empty list
            ST_EMPTY:
            begin
                if (slot_free)
                begin
                    push       = 1'b1;
                    push_addr  = '0;
                    push_value = '0;
                    push_link  = NULL_LINK;
                    push_eol   = 1'b1;
                    push_empty = 1'b1;
                    trunc_next = 1'b0;
                    len_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            // record the node and read its link
            ST_WALK_RD:
            begin
                order_we   = 1'b1;
                n_next     = n_reg + CNT_W'(1);
                state_next = ST_WALK_CHK;
            end

            // follow the link or stop the walk
            ST_WALK_CHK:
            begin
                s_next         = '0;
                j_next         = '0;
                have_pend_next = 1'b0;
                len_next       = n_reg;
                if (link_rdata[LINK_W-1])
                begin
                    trunc_next = 1'b0;
                    state_next = ST_EM_ADDR;
                end
                else if (n_reg == CNT_W'(MAX_NODES))
                begin
                    trunc_next = 1'b1;
                    state_next = ST_EM_ADDR;
                end
                else
                begin
                    cur_next   = link_rdata[ADDR_BITS-1:0];
                    state_next = ST_WALK_RD;
                end
            end

            // read the walk list at the mapped position
            ST_EM_ADDR:
            begin
                state_next = ST_EM_VAL;
            end

            // hold the node address, read its value
            ST_EM_VAL:
            begin
                cur_next   = order_rdata;
                state_next = ST_EM_LOAD;
            end

            // capture the value
            ST_EM_LOAD:
            begin
                cur_value_next = value_rdata;
                state_next     = ST_EM_PUSH;
            end

            // send the pending node linked to this one, then advance
            ST_EM_PUSH:
            begin
                if (!have_pend_reg || slot_free)
                begin
                    push            = have_pend_reg;
                    have_pend_next  = 1'b1;
                    pend_addr_next  = cur_reg;
                    pend_value_next = cur_value_reg;
                    if (j_reg + GRP_W'(1) == k_eff)
                    begin
                        s_next = s_reg + POS_W'(k_eff);
                        j_next = '0;
                    end
                    else
                    begin
                        j_next = j_reg + GRP_W'(1);
                    end
                    if (next_pos == POS_W'(len_reg))
                    begin
                        state_next = ST_EM_LAST;
                    end
                    else
                    begin
                        state_next = ST_EM_ADDR;
                    end
                end
            end

            // send the last node with a null link
            ST_EM_LAST:
            begin
                if (slot_free)
                begin
                    push           = 1'b1;
                    push_link      = NULL_LINK;
                    push_eol       = 1'b1;
                    have_pend_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output word register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_addr_reg  <= push_addr;
            out_value_reg <= push_value;
            out_link_reg  <= push_link;
            out_eol_reg   <= push_eol;
            out_empty_reg <= push_empty;
            out_trunc_reg <= push_empty ? 1'b0 : trunc_reg;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.out_addr    = out_addr_reg;
    assign result_out.out_value   = out_value_reg;
    assign result_out.out_link    = out_link_reg;
    assign result_out.end_of_list = out_eol_reg;
    assign result_out.list_empty  = out_empty_reg;
    assign result_out.truncated   = out_trunc_reg;

endmodule
